// File: sv/abcc_pkg.sv
// abcc_pkg: shared types, constants and the linearization table of the
// alpha blend contrast checker; no dependencies
`default_nettype none

package abcc_pkg;

  // fixed point fraction of linear light and luminance
  localparam int LumaFracBits = 16;
  localparam int LumaW = LumaFracBits + 1;
  localparam logic [LumaW-1:0] LumaOne = LumaW'(1) << LumaFracBits;

  // configuration register indexes
  localparam logic [1:0] RegWarnThreshold = 2'd0;
  localparam logic [1:0] RegDarkBackdrop  = 2'd1;
  localparam logic [1:0] RegLightBackdrop = 2'd2;

  // reset values of the configuration registers
  localparam logic [11:0] WarnThresholdReset = 12'd450;
  localparam logic [7:0]  DarkBackdropReset  = 8'd0;
  localparam logic [7:0]  LightBackdropReset = 8'd255;

  typedef struct packed {
    logic [7:0] surface_red;
    logic [7:0] surface_green;
    logic [7:0] surface_blue;
    logic [7:0] surface_alpha;
    logic [7:0] text_red;
    logic [7:0] text_green;
    logic [7:0] text_blue;
    logic [7:0] window_red;
    logic [7:0] window_green;
    logic [7:0] window_blue;
  } in_item_t;

  typedef struct packed {
    logic [11:0] opaque_contrast;
    logic [11:0] worst_contrast;
    logic        below_threshold;
    logic        window_matches;
  } out_item_t;

  typedef struct packed {
    logic [11:0] warn_threshold;
    logic [7:0]  dark_backdrop;
    logic [7:0]  light_backdrop;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // four colors to rate, plus the window compare
  typedef struct packed {
    rgb_t opaque;
    rgb_t text;
    rgb_t dark;
    rgb_t light;
    logic win_match;
  } colors_t;

  typedef struct packed {
    logic [LumaW-1:0] opaque;
    logic [LumaW-1:0] text;
    logic [LumaW-1:0] dark;
    logic [LumaW-1:0] light;
    logic             win_match;
  } lumas_t;

  typedef logic [LumaW-1:0] lin_tab_t [256];

  // one table entry, evaluated at elaboration only
  function automatic logic [LumaW-1:0] lin_entry(int v);
    real x;
    real y;
    if (v <= 10) begin
      return LumaW'((2 * v * 100 * (longint'(1) << LumaFracBits) + 329460) / 658920);
    end
    x = v / 255.0;
    y = ((x + 0.055) / 1.055) ** 2.4;
    return LumaW'($rtoi(y * (2.0 ** LumaFracBits) + 0.5));
  endfunction

  function automatic lin_tab_t build_lin_table();
    lin_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = lin_entry(i);
    end
    return t;
  endfunction

  // srgb to linear light, 1.0 = 2^LumaFracBits
  localparam lin_tab_t LinTable = build_lin_table();

endpackage

`default_nettype wire

// File: sv/abcc_blend.sv
// abcc_blend: two stage compositing of the surface over both backdrops
// depends on abcc_pkg
`default_nettype none

module abcc_blend
  import abcc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output colors_t       out_colors
);

  // stage a: blend sums before the divide by 255
  logic        va;
  logic        ena;
  logic        enb;
  rgb_t        surf_a;
  rgb_t        text_a;
  logic        match_a;
  logic [15:0] dsum [3];
  logic [15:0] lsum [3];
  logic [15:0] dsum_next [3];
  logic [15:0] lsum_next [3];

  function automatic logic [15:0] mix(logic [7:0] c, logic [7:0] a, logic [7:0] g);
    logic [15:0] p;
    logic [15:0] q;
    p = {8'd0, c} * {8'd0, a};
    q = {8'd0, g} * {8'd0, 8'd255 - a};
    return p + q + 16'd127;
  endfunction

  // exact x / 255 for the range of a blend sum
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  assign enb = !out_valid || out_ready;
  assign ena = !va || enb;
  assign in_ready = ena;

  always_comb begin
    dsum_next[0] = mix(in_item.surface_red,   in_item.surface_alpha, cfg.dark_backdrop);
    dsum_next[1] = mix(in_item.surface_green, in_item.surface_alpha, cfg.dark_backdrop);
    dsum_next[2] = mix(in_item.surface_blue,  in_item.surface_alpha, cfg.dark_backdrop);
    lsum_next[0] = mix(in_item.surface_red,   in_item.surface_alpha, cfg.light_backdrop);
    lsum_next[1] = mix(in_item.surface_green, in_item.surface_alpha, cfg.light_backdrop);
    lsum_next[2] = mix(in_item.surface_blue,  in_item.surface_alpha, cfg.light_backdrop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ena) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      surf_a  <= '{in_item.surface_red, in_item.surface_green, in_item.surface_blue};
      text_a  <= '{in_item.text_red, in_item.text_green, in_item.text_blue};
      match_a <= (in_item.surface_red == in_item.window_red) &&
                 (in_item.surface_green == in_item.window_green) &&
                 (in_item.surface_blue == in_item.window_blue);
      dsum    <= dsum_next;
      lsum    <= lsum_next;
    end
  end

  // stage b: rounded composited channels
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enb) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (enb) begin
      out_colors.opaque    <= surf_a;
      out_colors.text      <= text_a;
      out_colors.win_match <= match_a;
      out_colors.dark      <= '{div255(dsum[0]), div255(dsum[1]), div255(dsum[2])};
      out_colors.light     <= '{div255(lsum[0]), div255(lsum[1]), div255(lsum[2])};
    end
  end

endmodule

`default_nettype wire

// File: sv/abcc_luma.sv
// abcc_luma: four stage relative luminance of four colors
// depends on abcc_pkg (linearization table and types)
`default_nettype none

module abcc_luma
  import abcc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire colors_t in_colors,
  output logic         out_valid,
  input  wire logic    out_ready,
  output lumas_t       out_lumas
);

  localparam int SumW = LumaW + 14;
  localparam int TW = SumW - 4;
  localparam int RecipShift = 36;
  localparam logic [26:0] Recip625 = 27'd109951162;

  // color order: opaque, text, dark, light
  logic             vc, vd, ve;
  logic             enc, end_, ene, enf;
  logic [LumaW-1:0] lin [4][3];
  logic [TW-1:0]    tq_d [4];
  logic [TW-1:0]    tq_e [4];
  logic [LumaW-1:0] qe [4];
  logic             mc, md, me;
  rgb_t             col [4];

  assign col[0] = in_colors.opaque;
  assign col[1] = in_colors.text;
  assign col[2] = in_colors.dark;
  assign col[3] = in_colors.light;

  assign enf = !out_valid || out_ready;
  assign ene = !ve || enf;
  assign end_ = !vd || ene;
  assign enc = !vc || end_;
  assign in_ready = enc;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (enc) vc <= in_valid;
      if (end_) vd <= vc;
      if (ene) ve <= vd;
      if (enf) out_valid <= ve;
    end
  end

  // stage c: table lookups
  always_ff @(posedge clk) begin
    if (enc) begin
      for (int i = 0; i < 4; i++) begin
        lin[i][0] <= LinTable[col[i].r];
        lin[i][1] <= LinTable[col[i].g];
        lin[i][2] <= LinTable[col[i].b];
      end
      mc <= in_colors.win_match;
    end
  end

  // stage d: weighted sum, rounded, then the factor 16 of 10000 dropped
  always_ff @(posedge clk) begin
    logic [SumW-1:0] s;
    if (end_) begin
      for (int i = 0; i < 4; i++) begin
        s = SumW'(lin[i][0]) * SumW'(2126) + SumW'(lin[i][1]) * SumW'(7152) +
            SumW'(lin[i][2]) * SumW'(722) + SumW'(5000);
        tq_d[i] <= s[SumW-1:4];
      end
      md <= mc;
    end
  end

  // stage e: reciprocal estimate of t / 625
  always_ff @(posedge clk) begin
    logic [TW+26:0] p;
    if (ene) begin
      for (int i = 0; i < 4; i++) begin
        p = (TW+27)'(tq_d[i]) * (TW+27)'(Recip625);
        qe[i] <= p[RecipShift +: LumaW];
      end
      tq_e <= tq_d;
      me <= md;
    end
  end

  // stage f: the estimate is low by at most one
  always_ff @(posedge clk) begin
    logic [LumaW-1:0] q [4];
    logic [TW-1:0]    r;
    if (enf) begin
      for (int i = 0; i < 4; i++) begin
        r = tq_e[i] - TW'(qe[i]) * TW'(625);
        q[i] = (r >= TW'(625)) ? qe[i] + LumaW'(1) : qe[i];
      end
      out_lumas.opaque    <= q[0];
      out_lumas.text      <= q[1];
      out_lumas.dark      <= q[2];
      out_lumas.light     <= q[3];
      out_lumas.win_match <= me;
    end
  end

endmodule

`default_nettype wire

// File: sv/abcc_ratio.sv
// abcc_ratio: contrast ratios through a pipelined restoring divider,
// worst case and threshold flag; depends on abcc_pkg
`default_nettype none

module abcc_ratio
  import abcc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire lumas_t in_lumas,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_item_t   out_item
);

  localparam int DenW = LumaW + 5;
  localparam int NumW = DenW + 7;
  localparam int QW = 12;
  localparam int DivStages = 4;
  localparam int BitsPerStage = QW / DivStages;

  // index 0 is the setup stage, 1..DivStages the divider stages
  logic              v   [DivStages+1];
  logic              en  [DivStages+1];
  logic [NumW-1:0]   rem [DivStages+1][3];
  logic [DenW-1:0]   den [DivStages+1][3];
  logic [QW-1:0]     quo [DivStages+1][3];
  logic              mt  [DivStages+1];
  logic              en_out;
  logic [LumaW-1:0]  ya [3];

  assign ya[0] = in_lumas.opaque;
  assign ya[1] = in_lumas.dark;
  assign ya[2] = in_lumas.light;

  // stall chain
  assign en_out = !out_valid || out_ready;
  always_comb begin
    en[DivStages] = !v[DivStages] || en_out;
    for (int k = DivStages - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DivStages; k++) v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k <= DivStages; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
      if (en_out) out_valid <= v[DivStages];
    end
  end

  // setup: order the pair, numerator and denominator
  always_ff @(posedge clk) begin
    logic [LumaW-1:0] hi;
    logic [LumaW-1:0] lo;
    logic [DenW-1:0]  h20;
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        hi = (ya[i] > in_lumas.text) ? ya[i] : in_lumas.text;
        lo = (ya[i] > in_lumas.text) ? in_lumas.text : ya[i];
        h20 = DenW'(hi) * DenW'(20) + DenW'(LumaOne);
        rem[0][i] <= NumW'(h20) * NumW'(100);
        den[0][i] <= DenW'(lo) * DenW'(20) + DenW'(LumaOne);
        quo[0][i] <= '0;
      end
      mt[0] <= in_lumas.win_match;
    end
  end

  // divider stages, a few quotient bits each
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    always_ff @(posedge clk) begin
      logic [NumW+QW-1:0] r;
      logic [NumW+QW-1:0] d;
      logic [QW-1:0]      q;
      int                 b;
      if (en[k]) begin
        for (int i = 0; i < 3; i++) begin
          r = (NumW+QW)'(rem[k-1][i]);
          q = quo[k-1][i];
          for (int j = 0; j < BitsPerStage; j++) begin
            b = QW - 1 - (k - 1) * BitsPerStage - j;
            d = (NumW+QW)'(den[k-1][i]) << b;
            if (r >= d) begin
              r = r - d;
              q[b] = 1'b1;
            end
          end
          rem[k][i] <= r[NumW-1:0];
          quo[k][i] <= q;
        end
        den[k] <= den[k-1];
        mt[k] <= mt[k-1];
      end
    end
  end

  // output register: worst case and flag
  always_ff @(posedge clk) begin
    logic [QW-1:0] w;
    if (en_out) begin
      w = (quo[DivStages][1] < quo[DivStages][2]) ? quo[DivStages][1] : quo[DivStages][2];
      out_item.opaque_contrast <= quo[DivStages][0];
      out_item.worst_contrast  <= w;
      out_item.below_threshold <= w < cfg.warn_threshold;
      out_item.window_matches  <= mt[DivStages];
    end
  end

`ifndef SYNTHESIS
  // divide finished: remainders below their divisors
  a_rem_done: assert property (@(posedge clk) disable iff (rst)
    v[DivStages] |-> (rem[DivStages][0] < NumW'(den[DivStages][0])) &&
                     (rem[DivStages][1] < NumW'(den[DivStages][1])) &&
                     (rem[DivStages][2] < NumW'(den[DivStages][2])))
    else $error("divider remainder not reduced");

  // ordered pair gives a ratio of at least one
  a_ratio_min: assert property (@(posedge clk) disable iff (rst)
    v[DivStages] |-> (quo[DivStages][0] >= QW'(100)) && (quo[DivStages][1] >= QW'(100)) &&
                     (quo[DivStages][2] >= QW'(100)))
    else $error("contrast ratio below one");
`endif

endmodule

`default_nettype wire

// File: sv/alpha_blend_contrast_checker_unit.sv
// alpha_blend_contrast_checker_unit: top level with the register port
// depends on abcc_pkg, abcc_blend, abcc_luma, abcc_ratio
//
// A request carries a translucent surface color, a text color and a window
// color; each request gives one result: contrast in hundredths of the opaque
// surface and of the worse of two composited backdrops against the text,
// a flag for a worst case below warn_threshold and a window match bit.
// Both channels use valid/ready. The register port is APB style, pready
// tied high, registers at 0x0 (warn_threshold), 0x4 (dark_backdrop) and
// 0x8 (light_backdrop); write only while no request is in flight.
// From request acceptance to result valid an item passes 2 blend
// stages, 4 luminance stages (table, weighted sum, reciprocal, correction),
// a setup stage, 4 divider stages at 3 quotient bits each and the output
// register. A new request is taken every cycle unless the result side
// stalls; the 12 quotient bits of the divider are spread over its 4 stages.
// Each stage holds its item while the next one is full, so a stalled
// receiver fills the bubbles first and then holds the request side off.
// Synchronous reset empties the pipeline and loads the register defaults.
`default_nettype none

module alpha_blend_contrast_checker_unit
  import abcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire in_item_t    item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output out_item_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  logic    b_valid, b_ready;
  colors_t b_colors;
  logic    l_valid, l_ready;
  lumas_t  l_lumas;

  // register writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_threshold <= WarnThresholdReset;
      cfg.dark_backdrop  <= DarkBackdropReset;
      cfg.light_backdrop <= LightBackdropReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        RegWarnThreshold: cfg.warn_threshold <= pwdata[11:0];
        RegDarkBackdrop:  cfg.dark_backdrop  <= pwdata[7:0];
        RegLightBackdrop: cfg.light_backdrop <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      RegWarnThreshold: prdata = {20'd0, cfg.warn_threshold};
      RegDarkBackdrop:  prdata = {24'd0, cfg.dark_backdrop};
      RegLightBackdrop: prdata = {24'd0, cfg.light_backdrop};
      default:          prdata = '0;
    endcase
  end

  abcc_blend u_blend (
    .clk, .rst, .cfg,
    .in_valid(item_valid), .in_ready(item_ready), .in_item(item),
    .out_valid(b_valid), .out_ready(b_ready), .out_colors(b_colors)
  );

  abcc_luma u_luma (
    .clk, .rst,
    .in_valid(b_valid), .in_ready(b_ready), .in_colors(b_colors),
    .out_valid(l_valid), .out_ready(l_ready), .out_lumas(l_lumas)
  );

  abcc_ratio u_ratio (
    .clk, .rst, .cfg,
    .in_valid(l_valid), .in_ready(l_ready), .in_lumas(l_lumas),
    .out_valid(result_valid), .out_ready(result_ready), .out_item(result)
  );

`ifndef SYNTHESIS
  // an empty output stage never holds requests off
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("request stalled with empty output");

  // flag agrees with worst case and threshold
  a_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.below_threshold == (result.worst_contrast < cfg.warn_threshold))
    else $error("threshold flag mismatch");
`endif

endmodule

`default_nettype wire
